// File: rtl/hid_keyboard_report_engine_unit_assert.svh
// assertion macros for the hid keyboard report engine
`ifndef HID_KEYBOARD_REPORT_ENGINE_UNIT_ASSERT_SVH
`define HID_KEYBOARD_REPORT_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HKR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hkr assertion failed");
`define HKR_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("hkr forbidden condition seen");
`else
`define HKR_ASSERT(name, clk, rst_n, prop)
`define HKR_NEVER(name, clk, rst_n, prop)
`endif
`endif

// File: rtl/hkr_pkg.sv
// shared types and constants of the hid keyboard report engine
package hkr_pkg;

  localparam int KEY_SLOTS    = 16;
  localparam int REPORT_BYTES = 8;
  localparam int REPORT_HDR   = 3;
  localparam int OUT_SLOTS    = 5;
  localparam int IDX_W        = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W        = $clog2(KEY_SLOTS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [7:0] SHIFT_BIT = 8'd1;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_MOD   = 2'd1,
    CMD_MEDIA = 2'd2,
    CMD_TYPE  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] code;
    logic       set;
    logic       shift;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/hid_keyboard_report_engine_unit.sv
// top level of the hid keyboard report engine
// Usage: drive operation_i, key_index_i, pressed_i and text_char_i with start high;
// the item is taken at the rising edge where start is high and busy is low.
// Each keyboard report appears for exactly one cycle with result_strobe_o high;
// last_o marks the final report of an item, key_dropped_o a press into a full store.
// Key press or release: one report, after the sorted-store scan walks the held
// codes below the target (0 to 16), one per cycle. Modifier or media bit: one
// report. Typed character: two reports, or four with shift, each key step
// passing through the scan, insert or erase and report stages.
// An unmapped character is accepted and produces no report.
// A two-entry command queue takes up to two items ahead of the back end;
// busy is high while the queue is full. Sustained rate is set by the back end
// scan: a new item leaves the queue only once the back end is idle again.
// Reset clears masks, key count, queue and sequencer; store contents are
// not cleared. The receiver cannot stall: results are never held back.
module hid_keyboard_report_engine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [7:0] key_index_i,
  input  logic       pressed_i,
  input  logic [7:0] text_char_i,
  output logic       result_strobe_o,
  output logic [7:0] modifiers_o,
  output logic [7:0] key_slot_0_o,
  output logic [7:0] key_slot_1_o,
  output logic [7:0] key_slot_2_o,
  output logic [7:0] key_slot_3_o,
  output logic [7:0] key_slot_4_o,
  output logic       last_o,
  output logic       key_dropped_o
);
  import hkr_pkg::*;

  q_status_t                 q_status;
  cmd_t                      push_cmd;
  cmd_t                      head_cmd;
  logic                      push;
  logic                      pop;
  logic [OUT_SLOTS-1:0][7:0] key_slots;

  hkr_front u_front (
    .start_i     (start),
    .operation_i (operation_i),
    .key_index_i (key_index_i),
    .pressed_i   (pressed_i),
    .text_char_i (text_char_i),
    .q_status_i  (q_status),
    .busy_o      (busy),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  hkr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  hkr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .strobe_o      (result_strobe_o),
    .modifiers_o   (modifiers_o),
    .key_slots_o   (key_slots),
    .last_o        (last_o),
    .key_dropped_o (key_dropped_o)
  );

  assign key_slot_0_o = key_slots[0];
  assign key_slot_1_o = key_slots[1];
  assign key_slot_2_o = key_slots[2];
  assign key_slot_3_o = key_slots[3];
  assign key_slot_4_o = key_slots[4];

endmodule

// File: rtl/hkr_front.sv
// front end: accepts items and classifies them into commands
module hkr_front (
  input  logic             start_i,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       key_index_i,
  input  logic             pressed_i,
  input  logic [7:0]       text_char_i,
  input  hkr_pkg::q_status_t q_status_i,
  output logic             busy_o,
  output logic             push_o,
  output hkr_pkg::cmd_t    cmd_o
);
  import hkr_pkg::*;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_MOD   = 2'd1,
    OP_MEDIA = 2'd2,
    OP_TYPE  = 2'd3
  } op_e;

  localparam logic [7:0] ASCII_SPACE   = 8'd32;
  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_ONE     = 8'd49;
  localparam logic [7:0] ASCII_NINE    = 8'd57;
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [7:0] HID_ZERO      = 8'd39;
  localparam logic [7:0] HID_SPACE     = 8'd44;
  localparam logic [7:0] HID_NONE      = 8'd0;
  localparam logic [7:0] DIGIT_OFFSET  = 8'd19;
  localparam logic [7:0] UPPER_OFFSET  = 8'd61;
  localparam logic [7:0] LOWER_OFFSET  = 8'd93;

  function automatic logic [7:0] char_to_hid(input logic [7:0] c);
    logic [7:0] code;
    priority if (c == ASCII_ZERO) begin
      code = HID_ZERO;
    end else if (c == ASCII_SPACE) begin
      code = HID_SPACE;
    end else if (c >= ASCII_ONE && c <= ASCII_NINE) begin
      code = c - DIGIT_OFFSET;
    end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      code = c - UPPER_OFFSET;
    end else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      code = c - LOWER_OFFSET;
    end else begin
      code = HID_NONE;
    end
    return code;
  endfunction

  logic [7:0] usage_code;
  logic       keep;

  assign usage_code = char_to_hid(text_char_i);

  always_comb begin
    cmd_o.code  = key_index_i;
    cmd_o.set   = pressed_i;
    cmd_o.shift = 1'b0;
    keep        = 1'b1;
    unique case (op_e'(operation_i))
      OP_KEY:   cmd_o.kind = CMD_KEY;
      OP_MOD:   cmd_o.kind = CMD_MOD;
      OP_MEDIA: cmd_o.kind = CMD_MEDIA;
      OP_TYPE: begin
        cmd_o.kind  = CMD_TYPE;
        cmd_o.code  = usage_code;
        cmd_o.set   = 1'b1;
        cmd_o.shift = (text_char_i >= ASCII_UPPER_A) && (text_char_i <= ASCII_UPPER_Z);
        // unmapped characters give no results at all
        keep        = (usage_code != HID_NONE);
      end
      default:  cmd_o.kind = CMD_KEY;
    endcase
  end

  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full && keep;

endmodule

// File: rtl/hkr_queue.sv
// command queue between front end and back end
module hkr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hkr_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output hkr_pkg::cmd_t      cmd_o,
  output hkr_pkg::q_status_t status_o
);
  import hkr_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign cmd_o          = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/hkr_back.sv
// back end: key store, modifier and media masks, report sequencing
`include "hid_keyboard_report_engine_unit_assert.svh"
module hkr_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  hkr_pkg::cmd_t                         cmd_i,
  input  hkr_pkg::q_status_t                    q_status_i,
  output logic                                  pop_o,
  output logic                                  strobe_o,
  output logic [7:0]                            modifiers_o,
  output logic [hkr_pkg::OUT_SLOTS-1:0][7:0]    key_slots_o,
  output logic                                  last_o,
  output logic                                  key_dropped_o
);
  import hkr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_SHIFT_OFF,
    S_EMIT
  } state_e;

  state_e                    state_q;
  state_e                    after_q;
  cmd_t                      cmd_q;
  logic                      press_q;
  logic                      typing_q;
  logic [15:0]               mod_q;
  logic [15:0]               media_q;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          count_d;
  logic [CNT_W-1:0]          idx_q;
  logic [CNT_W-1:0]          pos_q;
  logic                      found_q;
  logic                      last_q;
  logic                      drop_q;
  logic                      strobe_q;
  logic [7:0]                out_mod_q;
  logic [OUT_SLOTS-1:0][7:0] out_slot_q;
  logic                      out_last_q;
  logic                      out_drop_q;
  logic [7:0]                store_q [KEY_SLOTS];
  logic [7:0]                store_d [KEY_SLOTS];
  logic [7:0]                scan_entry;
  logic                      scan_end;
  logic                      apply_drop;
  logic [OUT_SLOTS-1:0][7:0] slot_val;

  function automatic logic [15:0] set_bit(input logic [15:0] mask, input logic [7:0] idx,
                                          input logic val);
    logic [15:0] m;
    m = mask;
    if (idx[7:4] == 4'd0) begin
      m[idx[3:0]] = val;
    end
    return m;
  endfunction

  assign scan_entry = store_q[idx_q[IDX_W-1:0]];
  assign scan_end   = (idx_q >= count_q);
  assign pop_o      = (state_q == S_IDLE) && !q_status_i.empty;

  // sorted insert or erase, all entries past the position shifted together
  always_comb begin
    store_d    = store_q;
    count_d    = count_q;
    apply_drop = 1'b0;
    if (state_q == S_APPLY) begin
      if (press_q) begin
        if (!found_q) begin
          if (count_q == CNT_W'(KEY_SLOTS)) begin
            apply_drop = 1'b1;
          end else begin
            for (int j = 1; j < KEY_SLOTS; j++) begin
              if (CNT_W'(j) > pos_q && CNT_W'(j) <= count_q) begin
                store_d[j] = store_q[j-1];
              end
            end
            store_d[pos_q[IDX_W-1:0]] = cmd_q.code;
            count_d = count_q + 1'b1;
          end
        end
      end else if (found_q) begin
        for (int j = 0; j < KEY_SLOTS - 1; j++) begin
          if (CNT_W'(j) >= pos_q && CNT_W'(j + 1) < count_q) begin
            store_d[j] = store_q[j+1];
          end
        end
        count_d = count_q - 1'b1;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < OUT_SLOTS; j++) begin
      if (j < KEY_SLOTS && j + REPORT_HDR < REPORT_BYTES && CNT_W'(j) < count_q) begin
        slot_val[j] = store_q[IDX_W'(j)];
      end else begin
        slot_val[j] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      after_q    <= S_IDLE;
      cmd_q      <= '0;
      press_q    <= 1'b0;
      typing_q   <= 1'b0;
      mod_q      <= '0;
      media_q    <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      pos_q      <= '0;
      found_q    <= 1'b0;
      last_q     <= 1'b0;
      drop_q     <= 1'b0;
      strobe_q   <= 1'b0;
      out_mod_q  <= '0;
      out_slot_q <= '0;
      out_last_q <= 1'b0;
      out_drop_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      count_q  <= count_d;
      unique case (state_q)
        S_IDLE: begin
          if (!q_status_i.empty) begin
            cmd_q   <= cmd_i;
            idx_q   <= '0;
            drop_q  <= 1'b0;
            last_q  <= 1'b1;
            after_q <= S_IDLE;
            unique case (cmd_i.kind)
              CMD_KEY: begin
                press_q  <= cmd_i.set;
                typing_q <= 1'b0;
                state_q  <= S_SCAN;
              end
              CMD_MOD: begin
                mod_q   <= set_bit(mod_q, cmd_i.code, cmd_i.set);
                state_q <= S_EMIT;
              end
              CMD_MEDIA: begin
                media_q <= set_bit(media_q, cmd_i.code, cmd_i.set);
                state_q <= S_EMIT;
              end
              CMD_TYPE: begin
                press_q  <= 1'b1;
                typing_q <= 1'b1;
                if (cmd_i.shift) begin
                  mod_q   <= set_bit(mod_q, SHIFT_BIT, 1'b1);
                  last_q  <= 1'b0;
                  after_q <= S_SCAN;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_end || scan_entry >= cmd_q.code) begin
            pos_q   <= idx_q;
            found_q <= !scan_end && (scan_entry == cmd_q.code);
            state_q <= S_APPLY;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_APPLY: begin
          drop_q  <= apply_drop;
          idx_q   <= '0;
          state_q <= S_EMIT;
          if (typing_q && press_q) begin
            last_q  <= 1'b0;
            press_q <= 1'b0;
            after_q <= S_SCAN;
          end else if (typing_q && cmd_q.shift) begin
            last_q  <= 1'b0;
            after_q <= S_SHIFT_OFF;
          end else begin
            last_q  <= 1'b1;
            after_q <= S_IDLE;
          end
        end
        S_SHIFT_OFF: begin
          mod_q   <= set_bit(mod_q, SHIFT_BIT, 1'b0);
          drop_q  <= 1'b0;
          last_q  <= 1'b1;
          after_q <= S_IDLE;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          strobe_q   <= 1'b1;
          out_mod_q  <= mod_q[7:0];
          out_slot_q <= slot_val;
          out_last_q <= last_q;
          out_drop_q <= drop_q;
          state_q    <= after_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign strobe_o      = strobe_q;
  assign modifiers_o   = out_mod_q;
  assign key_slots_o   = out_slot_q;
  assign last_o        = out_last_q;
  assign key_dropped_o = out_drop_q;

  `HKR_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CNT_W'(KEY_SLOTS))
  `HKR_ASSERT(a_strobe_single, clk_i, rst_ni, strobe_q |=> !strobe_q)
  `HKR_ASSERT(a_drop_full, clk_i, rst_ni, (strobe_q && out_drop_q) |-> count_q == CNT_W'(KEY_SLOTS))
  `HKR_ASSERT(a_count_hold, clk_i, rst_ni, (state_q != S_APPLY) |=> $stable(count_q))
  `HKR_NEVER(a_pop_busy, clk_i, rst_ni, pop_o && state_q != S_IDLE)

endmodule

// File: tb/testbench.sv
// self-checking testbench for the hid keyboard report engine unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hkr_pkg::*;

  localparam int TARGET_ITEMS = 200;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    cmd_kind_e  op;
    logic [7:0] key;
    logic       pr;
    logic [7:0] ch;
  } key_event_t;

  typedef struct {
    logic [7:0]                    mods;
    logic [OUT_SLOTS-1:0][7:0]     slots;
    logic                          fin;
    logic                          dropped;
  } report_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] operation_i = CMD_KEY;
  logic [7:0] key_index_i = 8'd0;
  logic       pressed_i = 1'b0;
  logic [7:0] text_char_i = 8'd0;
  logic       result_strobe_o;
  logic [7:0] modifiers_o;
  logic [7:0] key_slot_0_o;
  logic [7:0] key_slot_1_o;
  logic [7:0] key_slot_2_o;
  logic [7:0] key_slot_3_o;
  logic [7:0] key_slot_4_o;
  logic       last_o;
  logic       key_dropped_o;

  hid_keyboard_report_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .key_index_i     (key_index_i),
    .pressed_i       (pressed_i),
    .text_char_i     (text_char_i),
    .result_strobe_o (result_strobe_o),
    .modifiers_o     (modifiers_o),
    .key_slot_0_o    (key_slot_0_o),
    .key_slot_1_o    (key_slot_1_o),
    .key_slot_2_o    (key_slot_2_o),
    .key_slot_3_o    (key_slot_3_o),
    .key_slot_4_o    (key_slot_4_o),
    .last_o          (last_o),
    .key_dropped_o   (key_dropped_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // predicted keyboard state
  logic [15:0] mod_mask = 16'd0;
  logic [15:0] media_mask = 16'd0;
  logic [7:0]  held_codes [KEY_SLOTS];
  int          held_cnt = 0;

  key_event_t  pending_events[$];
  report_t     reports_due[$];
  key_event_t  cur_evt;
  bit          taken = 1'b0;
  int          total_events = 0;
  int          sent_cnt = 0;
  int          accepted_cnt = 0;
  int          report_cnt = 0;
  int          drop_cnt = 0;
  int          max_held = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          gen_cnt = 0;
  int          chord_codes[$];

  function automatic logic [7:0] char_usage(logic [7:0] c);
    if (c == 8'd48) return 8'd39;
    if (c == 8'd32) return 8'd44;
    if (c >= 8'd49 && c <= 8'd57) return c - 8'd19;
    if (c >= 8'd65 && c <= 8'd90) return c - 8'd61;
    if (c >= 8'd97 && c <= 8'd122) return c - 8'd93;
    return 8'd0;
  endfunction

  function automatic bit apply_key(logic [7:0] code, bit press);
    int  pos;
    bit  found;
    pos = 0;
    while (pos < held_cnt && held_codes[pos] < code) pos++;
    found = (pos < held_cnt) && (held_codes[pos] == code);
    if (press) begin
      if (found) return 1'b0;
      if (held_cnt >= KEY_SLOTS) return 1'b1;
      for (int i = held_cnt; i > pos; i--) held_codes[i] = held_codes[i-1];
      held_codes[pos] = code;
      held_cnt++;
      if (held_cnt > max_held) max_held = held_cnt;
    end else if (found) begin
      for (int i = pos; i + 1 < held_cnt; i++) held_codes[i] = held_codes[i+1];
      held_cnt--;
    end
    return 1'b0;
  endfunction

  function automatic void push_report(bit dropped, bit fin);
    report_t r;
    r.mods = mod_mask[7:0];
    for (int j = 0; j < OUT_SLOTS; j++) begin
      if (j < held_cnt && j + REPORT_HDR < REPORT_BYTES) r.slots[j] = held_codes[j];
      else r.slots[j] = 8'd0;
    end
    r.fin = fin;
    r.dropped = dropped;
    reports_due.push_back(r);
  endfunction

  function automatic void predict_event(key_event_t e);
    logic [7:0] code;
    bit         shift;
    bit         d;
    case (e.op)
      CMD_KEY: begin
        d = apply_key(e.key, e.pr);
        push_report(d, 1'b1);
      end
      CMD_MOD: begin
        if (e.key < 8'd16) mod_mask[e.key[3:0]] = e.pr;
        push_report(1'b0, 1'b1);
      end
      CMD_MEDIA: begin
        if (e.key < 8'd16) media_mask[e.key[3:0]] = e.pr;
        push_report(1'b0, 1'b1);
      end
      default: begin
        code = char_usage(e.ch);
        shift = (e.ch >= 8'd65 && e.ch <= 8'd90);
        if (code != 8'd0) begin
          if (shift) begin
            mod_mask[SHIFT_BIT] = 1'b1;
            push_report(1'b0, 1'b0);
          end
          d = apply_key(code, 1'b1);
          push_report(d, 1'b0);
          d = apply_key(code, 1'b0);
          push_report(1'b0, !shift);
          if (shift) begin
            mod_mask[SHIFT_BIT] = 1'b0;
            push_report(1'b0, 1'b1);
          end
        end
      end
    endcase
  endfunction

  function automatic void add_event(cmd_kind_e op, logic [7:0] key, logic pr, logic [7:0] ch);
    key_event_t e;
    e.op = op;
    e.key = key;
    e.pr = pr;
    e.ch = ch;
    pending_events.push_back(e);
    if (op != CMD_TYPE || char_usage(ch) != 8'd0) gen_cnt++;
  endfunction

  function automatic logic [7:0] mapped_char();
    int k;
    k = $urandom_range(62);
    if (k == 0) return 8'd32;
    if (k <= 10) return 8'(48 + k - 1);
    if (k <= 36) return 8'(65 + k - 11);
    return 8'(97 + k - 37);
  endfunction

  // monitor and acceptance
  always @(posedge clk_i) begin
    report_t exp_r;
    logic [OUT_SLOTS-1:0][7:0] act_slots;
    if (rst_ni) begin
      cycle_cnt++;
      if (result_strobe_o) begin
        act_slots = {key_slot_4_o, key_slot_3_o, key_slot_2_o, key_slot_1_o, key_slot_0_o};
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected report mods=%h keys=%h", $time, modifiers_o, act_slots);
        end else begin
          exp_r = reports_due.pop_front();
          report_cnt++;
          if (key_dropped_o) drop_cnt++;
          if (modifiers_o !== exp_r.mods) begin
            errors++;
            $display("%0t: modifiers expected %h actual %h", $time, exp_r.mods, modifiers_o);
          end
          for (int j = 0; j < OUT_SLOTS; j++) begin
            if (act_slots[j] !== exp_r.slots[j]) begin
              errors++;
              $display("%0t: key_slot_%0d expected %h actual %h", $time, j,
                       exp_r.slots[j], act_slots[j]);
            end
          end
          if (last_o !== exp_r.fin) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, exp_r.fin, last_o);
          end
          if (key_dropped_o !== exp_r.dropped) begin
            errors++;
            $display("%0t: key_dropped expected %b actual %b", $time, exp_r.dropped,
                     key_dropped_o);
          end
        end
      end
      taken = start && !busy;
      if (taken) begin
        predict_event(cur_evt);
        accepted_cnt++;
      end
    end else begin
      taken = 1'b0;
    end
  end

  // driver
  always @(negedge clk_i) begin
    int idle_pct;
    key_event_t e;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (sent_cnt < total_events / 3) idle_pct = 22;
      else if (sent_cnt < 2 * total_events / 3) idle_pct = 52;
      else idle_pct = 0;
      if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct) begin
        e = pending_events.pop_front();
        cur_evt = e;
        sent_cnt++;
        start <= 1'b1;
        operation_i <= e.op;
        key_index_i <= e.key;
        pressed_i <= e.pr;
        text_char_i <= e.ch;
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("** hid_keyboard_report_engine_unit: FAILED **");
    $finish;
  end

  initial begin
    int r;
    int n;
    logic [7:0] code;
    for (int i = 0; i < KEY_SLOTS; i++) held_codes[i] = 8'd0;

    // directed corner cases
    add_event(CMD_KEY, 8'd0, 1'b1, 8'd0);
    add_event(CMD_KEY, 8'd255, 1'b1, 8'd255);
    add_event(CMD_KEY, 8'd0, 1'b1, 8'd0);
    add_event(CMD_KEY, 8'd100, 1'b0, 8'd0);
    add_event(CMD_MOD, 8'd0, 1'b1, 8'd0);
    add_event(CMD_MOD, 8'd15, 1'b1, 8'd0);
    add_event(CMD_MOD, 8'd16, 1'b1, 8'd0);
    add_event(CMD_MOD, 8'd255, 1'b0, 8'd0);
    add_event(CMD_MEDIA, 8'd3, 1'b1, 8'd0);
    add_event(CMD_MEDIA, 8'd200, 1'b1, 8'd0);
    add_event(CMD_MEDIA, 8'd3, 1'b0, 8'd0);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd65);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd90);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd97);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd122);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd48);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd49);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd57);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd32);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd255);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd0);
    add_event(CMD_KEY, 8'd4, 1'b1, 8'd0);
    add_event(CMD_TYPE, 8'd0, 1'b0, 8'd97);
    add_event(CMD_KEY, 8'd0, 1'b0, 8'd0);
    add_event(CMD_KEY, 8'd255, 1'b0, 8'd0);

    while (gen_cnt < TARGET_ITEMS) begin
      r = $urandom_range(99);
      if (r < 30) begin
        // typed word
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99) < 85) code = mapped_char();
          else code = 8'($urandom_range(255));
          add_event(CMD_TYPE, 8'($urandom_range(255)), 1'($urandom_range(1)), code);
        end
      end else if (r < 55) begin
        // chord: press a group of keys, release most of them
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(1)) code = 8'($urandom_range(4, 40));
          else code = 8'($urandom_range(255));
          chord_codes.push_back(code);
          add_event(CMD_KEY, code, 1'b1, 8'($urandom_range(255)));
          if ($urandom_range(99) < 15)
            add_event(CMD_MOD, 8'($urandom_range(15)), 1'($urandom_range(1)), 8'd0);
        end
        chord_codes.shuffle();
        for (int i = chord_codes.size() - 1; i >= 0; i--) begin
          if ($urandom_range(99) < 80) begin
            add_event(CMD_KEY, 8'(chord_codes[i]), 1'b0, 8'($urandom_range(255)));
            chord_codes.delete(i);
          end
        end
      end else if (r < 75) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99) < 90) code = 8'($urandom_range(15));
          else code = 8'($urandom_range(255));
          add_event($urandom_range(1) ? CMD_MOD : CMD_MEDIA, code, 1'($urandom_range(1)),
                    8'($urandom_range(255)));
        end
      end else if (r < 85) begin
        // release everything still held from chords
        while (chord_codes.size() > 0)
          add_event(CMD_KEY, 8'(chord_codes.pop_front()), 1'b0, 8'($urandom_range(255)));
      end else begin
        add_event(cmd_kind_e'($urandom_range(3)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
    total_events = pending_events.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == total_events);
    wait (reports_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (reports_due.size() != 0) begin
      errors++;
      $display("%0t: %0d reports never arrived", $time, reports_due.size());
    end

    $display("items accepted: %0d, reports checked: %0d, dropped presses: %0d",
             accepted_cnt, report_cnt, drop_cnt);
    $display("most keys held at once: %0d, mismatches: %0d", max_held, errors);
    if (errors == 0) begin
      $display("** hid_keyboard_report_engine_unit: PASSED **");
    end else begin
      $display("** hid_keyboard_report_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/hkr_pkg.sv
rtl/hkr_front.sv
rtl/hkr_queue.sv
rtl/hkr_back.sv
rtl/hid_keyboard_report_engine_unit.sv
tb/testbench.sv
